@@ rtl/rsiw_pkg.sv @@
// shared types and constants for the wilder rsi block
// no dependencies; imported by every module of the block

package rsiw_pkg;

  // default parameter values
  localparam int PRICE_WIDTH_DEF   = 32;
  localparam int AVG_FRAC_BITS_DEF = 16;
  localparam int PERIOD_MAX_DEF    = 255;

  // accumulator and average width, arithmetic wraps at this width
  localparam int ACC_W = 64;

  // period register
  localparam int                  PERIOD_W     = 8;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;

  // result scale: 100 scaled by 65536
  localparam int               RSI_W          = 23;
  localparam logic [RSI_W-1:0] RSI_FULL_SCALE = 23'd6553600;

  // quotient bits produced per step by the period divider
  localparam int PDIV_DIGIT_BITS = 4;

  // configuration port
  localparam int               CFG_DATA_W = 32;
  localparam int               CFG_ADDR_W = 3;
  localparam int               CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // latch the price of a new item
    logic delta;      // form gain and loss, update previous price and count
    logic acc;        // warm-up sums or smoothing numerators, start period divider
    logic pdiv_step;  // one digit of both period divisions
    logic avg_wr;     // write the quotients back into the averages
    logic rload;      // set up the ratio division
    logic rdiv_step;  // one bit of the ratio division
    logic out_load;   // move the result into the output register
  } rsiw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic first;      // no previous price yet
    logic item_ok;    // this item produces a valid rsi
    logic step_last;  // divider on its last step
    logic loss_zero;  // average loss is zero
  } rsiw_sts_t;

endpackage

@@ rtl/rsiw_ctrl.sv @@
// sequencing state machine for the wilder rsi block
// depends on rsiw_pkg; drives rsiw_dp through command and status structs

module rsiw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rsiw_pkg::rsiw_sts_t sts,
  output rsiw_pkg::rsiw_cmd_t cmd
);
  import rsiw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_ACC,
    S_PDIV,
    S_AVG,
    S_RLOAD,
    S_RDIV,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd.delta = 1'b1;
        state_nxt = sts.first ? S_FIN : S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.item_ok ? S_PDIV : S_FIN;
      end
      S_PDIV: begin
        cmd.pdiv_step = 1'b1;
        if (sts.step_last) begin
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        cmd.avg_wr = 1'b1;
        state_nxt  = S_RLOAD;
      end
      S_RLOAD: begin
        if (sts.loss_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rload = 1'b1;
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        cmd.rdiv_step = 1'b1;
        if (sts.step_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/rsiw_dp.sv @@
// datapath of the wilder rsi block: state, period divider, ratio divider
// depends on rsiw_pkg; commanded by rsiw_ctrl

module rsiw_dp #(
  parameter int PRICE_WIDTH   = rsiw_pkg::PRICE_WIDTH_DEF,
  parameter int AVG_FRAC_BITS = rsiw_pkg::AVG_FRAC_BITS_DEF,
  parameter int PERIOD_MAX    = rsiw_pkg::PERIOD_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rsiw_pkg::PERIOD_W-1:0] period,
  input  logic [PRICE_WIDTH-1:0]        in_price,
  input  rsiw_pkg::rsiw_cmd_t           cmd,
  output rsiw_pkg::rsiw_sts_t           sts,
  output logic [rsiw_pkg::RSI_W-1:0]    out_rsi_value,
  output logic                          out_rsi_valid
);
  import rsiw_pkg::*;

  localparam int PMAX_EFF   = (PERIOD_MAX < ((1 << PERIOD_W) - 1)) ?
                              PERIOD_MAX : ((1 << PERIOD_W) - 1);
  localparam int PER_W      = $clog2(PMAX_EFF + 1);
  localparam int CNT_W      = $clog2(PMAX_EFF + 2);
  localparam int DIG        = PDIV_DIGIT_BITS;
  localparam int PDIV_STEPS = ACC_W / DIG;
  localparam int STEP_MAX   = (PDIV_STEPS > RSI_W) ? PDIV_STEPS : RSI_W;
  localparam int STEP_W     = $clog2(STEP_MAX);
  localparam int NUM_W      = ACC_W + RSI_W;

  // one radix-2^DIG digit of a restoring division by the period
  function automatic logic [DIG+PER_W-1:0] pdiv_digit(
    input logic [PER_W-1:0] rem_in,
    input logic [DIG-1:0]   bits_in,
    input logic [PER_W-1:0] div
  );
    logic [PER_W:0] r;
    logic [DIG-1:0] q;
    r = {1'b0, rem_in};
    q = '0;
    for (int k = DIG - 1; k >= 0; k--) begin
      r = {r[PER_W-1:0], bits_in[k]};
      if (r >= {1'b0, div}) begin
        r    = r - {1'b0, div};
        q[k] = 1'b1;
      end
    end
    return {q, r[PER_W-1:0]};
  endfunction

  // architectural state
  logic [PRICE_WIDTH-1:0] prev_r, prev_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ACC_W-1:0]       avg_g_r, avg_g_nxt;
  logic [ACC_W-1:0]       avg_l_r, avg_l_nxt;

  // per-item working registers
  logic [PRICE_WIDTH-1:0] cur_r, cur_nxt;
  logic [ACC_W-1:0]       gain_d_r, gain_d_nxt;
  logic [ACC_W-1:0]       loss_d_r, loss_d_nxt;
  logic                   smooth_r, smooth_nxt;
  logic                   item_ok_r, item_ok_nxt;
  logic [ACC_W-1:0]       num_g_r, num_g_nxt;
  logic [ACC_W-1:0]       num_l_r, num_l_nxt;
  logic [PER_W-1:0]       rem_g_r, rem_g_nxt;
  logic [PER_W-1:0]       rem_l_r, rem_l_nxt;
  logic [ACC_W-1:0]       den_r, den_nxt;
  logic [ACC_W-1:0]       rrem_r, rrem_nxt;
  logic [RSI_W-1:0]       rlow_r, rlow_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [RSI_W-1:0]       res_val_r, res_val_nxt;
  logic                   res_ok_r, res_ok_nxt;

  // combinational helpers
  logic [PERIOD_W-1:0]      per_clip;
  logic [PER_W-1:0]         p_eff;
  logic [PER_W-1:0]         p_m1;
  logic [CNT_W-1:0]         p_ext;
  logic                     first, warm, seed;
  logic [ACC_W-1:0]         sum_g, sum_l;
  logic [ACC_W+PER_W-1:0]   mul_g, mul_l;
  logic [DIG+PER_W-1:0]     dg_g, dg_l;
  logic [ACC_W:0]           tot;
  logic [NUM_W-1:0]         scaled;
  logic [ACC_W:0]           rtrial;
  logic                     rq;
  logic [RSI_W-1:0]         q_clip;
  logic                     loss_zero;

  // period of zero acts as one, large periods clip to the maximum
  always_comb begin
    per_clip = (period == '0) ? PERIOD_W'(1) : period;
    if (per_clip > PERIOD_W'(PMAX_EFF)) begin
      per_clip = PERIOD_W'(PMAX_EFF);
    end
    p_eff = per_clip[PER_W-1:0];
    p_m1  = p_eff - PER_W'(1);
    p_ext = CNT_W'(p_eff);
  end

  assign first     = (cnt_r == '0);
  assign warm      = (cnt_r <= p_ext);
  assign seed      = (cnt_r == p_ext);
  assign loss_zero = (avg_l_r == '0);

  assign sum_g = avg_g_r + gain_d_r;
  assign sum_l = avg_l_r + loss_d_r;
  assign mul_g = avg_g_r * p_m1;
  assign mul_l = avg_l_r * p_m1;

  assign dg_g = pdiv_digit(rem_g_r, num_g_r[ACC_W-1 -: DIG], p_eff);
  assign dg_l = pdiv_digit(rem_l_r, num_l_r[ACC_W-1 -: DIG], p_eff);

  // denominator saturates on overflow; constant scale is a short shift-add
  assign tot    = {1'b0, avg_g_r} + {1'b0, avg_l_r};
  assign scaled = NUM_W'(avg_g_r) * NUM_W'(RSI_FULL_SCALE);

  always_comb begin
    rtrial = {rrem_r, rlow_r[RSI_W-1]};
    rq     = 1'b0;
    if (rtrial >= {1'b0, den_r}) begin
      rtrial = rtrial - {1'b0, den_r};
      rq     = 1'b1;
    end
  end

  assign q_clip = (rlow_r > RSI_FULL_SCALE) ? RSI_FULL_SCALE : rlow_r;

  always_comb begin
    prev_nxt    = prev_r;
    cnt_nxt     = cnt_r;
    avg_g_nxt   = avg_g_r;
    avg_l_nxt   = avg_l_r;
    cur_nxt     = cur_r;
    gain_d_nxt  = gain_d_r;
    loss_d_nxt  = loss_d_r;
    smooth_nxt  = smooth_r;
    item_ok_nxt = item_ok_r;
    num_g_nxt   = num_g_r;
    num_l_nxt   = num_l_r;
    rem_g_nxt   = rem_g_r;
    rem_l_nxt   = rem_l_r;
    den_nxt     = den_r;
    rrem_nxt    = rrem_r;
    rlow_nxt    = rlow_r;
    step_nxt    = step_r;
    res_val_nxt = res_val_r;
    res_ok_nxt  = res_ok_r;

    if (cmd.load) begin
      cur_nxt = in_price;
    end

    if (cmd.delta) begin
      prev_nxt    = cur_r;
      smooth_nxt  = ~warm;
      item_ok_nxt = ~first & (~warm | seed);
      if (cur_r > prev_r) begin
        gain_d_nxt = ACC_W'(cur_r - prev_r) << AVG_FRAC_BITS;
        loss_d_nxt = '0;
      end else begin
        gain_d_nxt = '0;
        loss_d_nxt = ACC_W'(prev_r - cur_r) << AVG_FRAC_BITS;
      end
      if (first) begin
        cnt_nxt = CNT_W'(1);
      end else if (warm) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        cnt_nxt = p_ext + CNT_W'(1);
      end
    end

    if (cmd.acc) begin
      rem_g_nxt = '0;
      rem_l_nxt = '0;
      step_nxt  = STEP_W'(PDIV_STEPS - 1);
      if (smooth_r) begin
        num_g_nxt = mul_g[ACC_W-1:0] + gain_d_r;
        num_l_nxt = mul_l[ACC_W-1:0] + loss_d_r;
      end else begin
        avg_g_nxt = sum_g;
        avg_l_nxt = sum_l;
        num_g_nxt = sum_g;
        num_l_nxt = sum_l;
      end
    end

    if (cmd.pdiv_step) begin
      num_g_nxt = {num_g_r[ACC_W-DIG-1:0], dg_g[DIG+PER_W-1:PER_W]};
      num_l_nxt = {num_l_r[ACC_W-DIG-1:0], dg_l[DIG+PER_W-1:PER_W]};
      rem_g_nxt = dg_g[PER_W-1:0];
      rem_l_nxt = dg_l[PER_W-1:0];
      step_nxt  = step_r - STEP_W'(1);
    end

    if (cmd.avg_wr) begin
      avg_g_nxt = num_g_r;
      avg_l_nxt = num_l_r;
    end

    if (cmd.rload) begin
      den_nxt  = tot[ACC_W] ? '1 : tot[ACC_W-1:0];
      rrem_nxt = scaled[NUM_W-1:RSI_W];
      rlow_nxt = scaled[RSI_W-1:0];
      step_nxt = STEP_W'(RSI_W - 1);
    end

    if (cmd.rdiv_step) begin
      rrem_nxt = rtrial[ACC_W-1:0];
      rlow_nxt = {rlow_r[RSI_W-2:0], rq};
      step_nxt = step_r - STEP_W'(1);
    end

    if (cmd.out_load) begin
      res_ok_nxt = item_ok_r;
      if (!item_ok_r) begin
        res_val_nxt = '0;
      end else if (loss_zero) begin
        res_val_nxt = RSI_FULL_SCALE;
      end else begin
        res_val_nxt = q_clip;
      end
    end
  end

  // running state clears on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      cnt_r   <= '0;
      avg_g_r <= '0;
      avg_l_r <= '0;
    end else begin
      prev_r  <= prev_nxt;
      cnt_r   <= cnt_nxt;
      avg_g_r <= avg_g_nxt;
      avg_l_r <= avg_l_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    gain_d_r  <= gain_d_nxt;
    loss_d_r  <= loss_d_nxt;
    smooth_r  <= smooth_nxt;
    item_ok_r <= item_ok_nxt;
    num_g_r   <= num_g_nxt;
    num_l_r   <= num_l_nxt;
    rem_g_r   <= rem_g_nxt;
    rem_l_r   <= rem_l_nxt;
    den_r     <= den_nxt;
    rrem_r    <= rrem_nxt;
    rlow_r    <= rlow_nxt;
    step_r    <= step_nxt;
    res_val_r <= res_val_nxt;
    res_ok_r  <= res_ok_nxt;
  end

  assign sts.first     = first;
  assign sts.item_ok   = item_ok_r;
  assign sts.step_last = (step_r == '0);
  assign sts.loss_zero = loss_zero;

  assign out_rsi_value = res_val_r;
  assign out_rsi_valid = res_ok_r;

endmodule

@@ rtl/relative_strength_index_wilder_unit.sv @@
// top level of the wilder rsi block: configuration register, controller, datapath
// depends on rsiw_pkg, rsiw_ctrl and rsiw_dp

// Wilder RSI over a stream of unsigned fixed-point prices, one result item per
// price item. The first price only primes the block; the next `period` price
// changes are summed as gains and losses, then divided by the period to seed the
// averages, and every later change is Wilder-smoothed with truncation. The result
// is 100*gain/(gain+loss) scaled by 65536, or full scale when the average loss is
// zero; rsi_valid stays low (value zero) until the averages are seeded. One item
// is worked on at a time: the first item and warm-up items skip both dividers, an
// item whose average loss is zero skips the ratio divider, and every other item
// runs through two dividers, one after the other:
// a 16-step radix-16 divider by the period (gain and loss lanes side by side)
// and a 23-step bit-serial divider for the final ratio. The result sits in an
// output register, so the next item is accepted while it waits. The period
// register (byte address 0, reset 14) must only be written while the block is
// idle; a period of zero acts as one, and one above PERIOD_MAX as PERIOD_MAX.

module relative_strength_index_wilder_unit #(
  parameter int PRICE_WIDTH   = rsiw_pkg::PRICE_WIDTH_DEF,
  parameter int AVG_FRAC_BITS = rsiw_pkg::AVG_FRAC_BITS_DEF,
  parameter int PERIOD_MAX    = rsiw_pkg::PERIOD_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // price items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [PRICE_WIDTH-1:0]          in_price,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rsiw_pkg::RSI_W-1:0]      out_rsi_value,
  output logic                            out_rsi_valid,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rsiw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rsiw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rsiw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import rsiw_pkg::*;

  logic [PERIOD_W-1:0]  period_r, period_nxt;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  rsiw_cmd_t            cmd;
  rsiw_sts_t            sts;

  // register file: a single period register, writes take effect on the access phase
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    period_nxt = period_r;
    if (wr_en && (reg_idx == REG_PERIOD)) begin
      period_nxt = pwdata[PERIOD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_PERIOD: prdata = CFG_DATA_W'(period_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else begin
      period_r <= period_nxt;
    end
  end

  // sequencing
  rsiw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // state, dividers and the output register
  rsiw_dp #(
    .PRICE_WIDTH   (PRICE_WIDTH),
    .AVG_FRAC_BITS (AVG_FRAC_BITS),
    .PERIOD_MAX    (PERIOD_MAX)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .period        (period_r),
    .in_price      (in_price),
    .cmd           (cmd),
    .sts           (sts),
    .out_rsi_value (out_rsi_value),
    .out_rsi_valid (out_rsi_valid)
  );

  // warm-up results carry a zero value
  a_warmup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsi_valid |-> out_rsi_value == '0)
    else $error("warm-up result with nonzero rsi value");

  // rsi never exceeds full scale
  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsi_value <= RSI_FULL_SCALE)
    else $error("rsi value above full scale");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

endmodule
